// ===== sv/assert_macros.svh =====
// Assertion macros used by the orientation histogram back end.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SOH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("orientation histogram assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SOH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("orientation histogram assertion failed");

`endif

// ===== sv/soh_pkg.sv =====
// Package of the orientation histogram block: constants, beat types and codes.
// Used by every module of the block; depends on nothing.
`default_nettype none

package soh_pkg;

  localparam int BINS       = 36;
  localparam int BIN_W      = $clog2(BINS);
  localparam int CNT_W      = $clog2(BINS + 2);
  localparam int MAX_RADIUS = 64;
  localparam int RAD_W      = $clog2(MAX_RADIUS + 1);
  localparam int RESULT_CAP = 18;
  localparam int CAP_W      = $clog2(RESULT_CAP + 1);

  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 48;
  localparam int DIV_CNT_W = 7;

  localparam int HORNER_TERMS = 10;
  localparam int SQUARINGS    = 4;

  typedef enum logic [1:0] {
    REG_WINDOW_FACTOR = 2'd0,
    REG_RADIUS_FACTOR = 2'd1,
    REG_PEAK_RATIO    = 2'd2,
    REG_SMOOTH_COUNT  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [11:0] window_factor;
    logic [11:0] radius_factor;
    logic [7:0]  peak_ratio;
    logic [2:0]  smooth_count;
  } cfg_t;

  typedef struct packed {
    logic [11:0]       key_x;
    logic [11:0]       key_y;
    logic [12:0]       level_width;
    logic [12:0]       level_height;
    logic [11:0]       kp_scale;
    logic signed [7:0] offset_x;
    logic signed [7:0] offset_y;
    logic [15:0]       grad_angle;
    logic [15:0]       grad_magnitude;
    logic              final_sample;
  } item_t;

  typedef struct packed {
    logic [15:0] peak_angle;
    logic        found;
    logic        run_end;
  } res_t;

  typedef struct packed {
    logic             kept;
    logic [BIN_W-1:0] bin;
    logic [15:0]      d2;
    logic [23:0]      sq;
    logic [15:0]      mag;
    logic             fin;
  } work_t;

endpackage

`default_nettype wire

// ===== sv/soh_divider.sv =====
// Restoring divider, one quotient bit per cycle, shared by the back end.
// Depends on soh_pkg for its widths.
`default_nettype none

module soh_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [soh_pkg::DIV_NUM_W-1:0] num,
  input  logic [soh_pkg::DIV_DEN_W-1:0] den,
  input  logic [soh_pkg::DIV_CNT_W-1:0] iter,
  output logic                          busy,
  output logic [soh_pkg::DIV_NUM_W-1:0] quot
);

  logic [soh_pkg::DIV_DEN_W-1:0] rem;
  logic [soh_pkg::DIV_DEN_W-1:0] den_r;
  logic [soh_pkg::DIV_NUM_W-1:0] numsh;
  logic [soh_pkg::DIV_CNT_W-1:0] cnt;
  logic [soh_pkg::DIV_DEN_W:0]   trial;
  logic [soh_pkg::DIV_DEN_W:0]   diff;
  logic                          ge;

  assign trial = {rem, numsh[soh_pkg::DIV_NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};
  assign busy  = cnt != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      rem   <= '0;
      den_r <= den;
      numsh <= num;
      quot  <= '0;
      cnt   <= iter;
    end else if (busy) begin
      rem   <= ge ? diff[soh_pkg::DIV_DEN_W-1:0] : trial[soh_pkg::DIV_DEN_W-1:0];
      numsh <= {numsh[soh_pkg::DIV_NUM_W-2:0], 1'b0};
      quot  <= {quot[soh_pkg::DIV_NUM_W-2:0], ge};
      cnt   <= cnt - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== sv/soh_front.sv =====
// Front end: takes sample beats, tests border and window, picks the bin,
// and queues classified work for the back end. Depends on soh_pkg.
`default_nettype none

module soh_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  soh_pkg::item_t     item,
  input  soh_pkg::cfg_t      cfg,
  input  logic               init_busy,
  output logic               q_valid,
  output soh_pkg::work_t     q_entry,
  input  logic               q_pop
);

  localparam int QDEPTH  = 2;
  localparam int BPROD_W = 16 + $clog2(soh_pkg::BINS + 1);

  logic           valid1;
  soh_pkg::item_t it1;

  logic                      valid2;
  logic                      border2;
  logic [soh_pkg::RAD_W-1:0] rad2;
  logic [15:0]               d2_2;
  logic [soh_pkg::BIN_W-1:0] bin2;
  logic [23:0]               sq2;
  logic [15:0]               mag2;
  logic                      fin2;

  soh_pkg::work_t qmem [QDEPTH];
  logic           wp;
  logic           rp;
  logic [1:0]     qcnt;

  logic accept;
  logic adv1;
  logic adv2;
  logic q_push;

  logic signed [14:0] nx;
  logic signed [14:0] ny;
  logic signed [14:0] lwm1;
  logic signed [14:0] lhm1;
  logic               border;
  logic [24:0]        rad_sum;
  logic [8:0]         rad_raw;
  logic [soh_pkg::RAD_W-1:0] rad_sat;
  logic signed [15:0] sqx;
  logic signed [15:0] sqy;
  logic [15:0]        d2;
  logic [BPROD_W-1:0] bprod;
  logic [BPROD_W-17:0] bin_raw;
  logic [soh_pkg::BIN_W-1:0] bin;
  logic [23:0]        sq;
  logic [2*soh_pkg::RAD_W-1:0] rad_sq;
  soh_pkg::work_t     entry;

  assign nx   = $signed({3'b000, it1.key_x}) + {{7{it1.offset_x[7]}}, it1.offset_x};
  assign ny   = $signed({3'b000, it1.key_y}) + {{7{it1.offset_y[7]}}, it1.offset_y};
  assign lwm1 = $signed({2'b00, it1.level_width}) - 15'sd1;
  assign lhm1 = $signed({2'b00, it1.level_height}) - 15'sd1;
  assign border = (nx >= 15'sd1) && (nx < lwm1) && (ny >= 15'sd1) && (ny < lhm1);

  assign rad_sum = {13'b0, it1.kp_scale} * {13'b0, cfg.radius_factor} + 25'd32768;
  assign rad_raw = rad_sum[24:16];
  assign rad_sat = (rad_raw > 9'(soh_pkg::MAX_RADIUS)) ?
                   soh_pkg::RAD_W'(soh_pkg::MAX_RADIUS) : rad_raw[soh_pkg::RAD_W-1:0];

  assign sqx = it1.offset_x * it1.offset_x;
  assign sqy = it1.offset_y * it1.offset_y;
  assign d2  = 16'(sqx) + 16'(sqy);

  assign bprod   = BPROD_W'(it1.grad_angle) * BPROD_W'(soh_pkg::BINS) + BPROD_W'(32768);
  assign bin_raw = bprod[BPROD_W-1:16];
  assign bin     = (bin_raw >= (BPROD_W-16)'(soh_pkg::BINS)) ?
                   '0 : bin_raw[soh_pkg::BIN_W-1:0];

  assign sq = {12'b0, it1.kp_scale} * {12'b0, cfg.window_factor};

  assign rad_sq = {{soh_pkg::RAD_W{1'b0}}, rad2} * {{soh_pkg::RAD_W{1'b0}}, rad2};

  always_comb begin
    entry.kept = border2 && (d2_2 <= 16'(rad_sq));
    entry.bin  = bin2;
    entry.d2   = d2_2;
    entry.sq   = sq2;
    entry.mag  = mag2;
    entry.fin  = fin2;
  end

  assign q_push  = valid2 && (qcnt != 2'(QDEPTH));
  assign adv2    = !valid2 || q_push;
  assign adv1    = !valid1 || adv2;
  assign full    = !adv1 || init_busy;
  assign accept  = push && !full;
  assign q_valid = qcnt != '0;
  assign q_entry = qmem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      wp     <= 1'b0;
      rp     <= 1'b0;
      qcnt   <= '0;
    end else begin
      if (adv1) begin
        valid1 <= accept;
      end
      if (accept) begin
        it1 <= item;
      end
      if (adv2) begin
        valid2 <= valid1;
      end
      if (adv2 && valid1) begin
        border2 <= border;
        rad2    <= rad_sat;
        d2_2    <= d2;
        bin2    <= bin;
        sq2     <= sq;
        mag2    <= it1.grad_magnitude;
        fin2    <= it1.final_sample;
      end
      if (q_push) begin
        qmem[wp] <= entry;
        wp       <= ~wp;
      end
      if (q_pop) begin
        rp <= ~rp;
      end
      qcnt <= qcnt + 2'(q_push) - 2'(q_pop);
    end
  end

endmodule

`default_nettype wire

// ===== sv/soh_back.sv =====
// Back end: Gaussian weighting, histogram memory, smoothing, peak scan,
// result queue and clearing. Depends on soh_pkg, soh_divider, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module soh_back (
  input  logic               clk,
  input  logic               rst,
  input  soh_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  soh_pkg::work_t     q_entry,
  output logic               q_pop,
  output logic               init_busy,
  input  logic               pop,
  output logic               empty,
  output soh_pkg::res_t      result
);

  localparam int RES_DEPTH = 4;
  localparam int RP_W      = $clog2(RES_DEPTH);
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  typedef enum logic [4:0] {
    IDLE, SQ_MUL, T_START, T_WAIT, H_MUL, H_REC, H_SUB, S_MUL, S_RND,
    W_CALC, M_MUL, A_RD, A_WR, FIN, SM_RD, SM_SH, MX_RD, MX_SH,
    SC_RD, SC_SH, SC_T1, SC_T2, SC_I1, SC_I2, SC_I3, SC_IW, SC_EMIT,
    SC_NEXT, SC_END, CLEAR
  } state_t;

  state_t state;

  soh_pkg::work_t            wk;
  logic [soh_pkg::CNT_W-1:0] j;
  logic [2:0]                pass;
  logic [3:0]                k;
  logic [1:0]                n;
  logic [soh_pkg::BIN_W-1:0] s;
  logic [1:0]                sub;
  logic [soh_pkg::CAP_W-1:0] count;
  logic [29:0]               x;
  logic [30:0]               r;
  logic [16:0]               w;
  logic [16:0]               add;
  logic [31:0]               w1;
  logic [31:0]               w2;
  logic [31:0]               old0;
  logic [31:0]               hp;
  logic [31:0]               hh;
  logic [31:0]               hn;
  logic [31:0]               peak;
  logic [33:0]               dp;
  logic [63:0]               numer;
  soh_pkg::res_t             pend;
  logic                      pend_valid;

  logic [33:0] mul_a;
  logic [31:0] mul_b;
  logic [65:0] prod;

  logic [31:0]               hist [soh_pkg::BINS];
  logic [soh_pkg::BIN_W-1:0] rd_addr;
  logic [31:0]               rd_data;
  logic                      mem_we;
  logic [soh_pkg::BIN_W-1:0] wa;
  logic [31:0]               wd;

  logic                          div_start;
  logic [soh_pkg::DIV_NUM_W-1:0] div_num;
  logic [soh_pkg::DIV_DEN_W-1:0] div_den;
  logic [soh_pkg::DIV_CNT_W-1:0] div_iter;
  logic                          div_busy;
  logic [soh_pkg::DIV_NUM_W-1:0] quot;

  soh_pkg::res_t rmem [RES_DEPTH];
  logic [RP_W-1:0] rwp;
  logic [RP_W-1:0] rrp;
  logic [RP_W:0]   rcnt;
  logic            res_full;
  logic            res_push;
  logic            res_pop;
  soh_pkg::res_t   res_data;

  logic [31:0]               sm_data;
  logic [33:0]               sm_sum;
  logic [32:0]               acc_sum;
  logic [soh_pkg::BIN_W-1:0] s_prev;
  logic [soh_pkg::BIN_W-1:0] s_next;
  logic                      peak_ok;

  // Reciprocals ceil(2^33 / kk); a 30-bit value times one of them, shifted
  // right by 33, gives the exact floor quotient.
  function automatic logic [33:0] recip(input logic [3:0] kk);
    logic [33:0] m;
    unique case (kk)
      4'd1:    m = 34'h2_0000_0000;
      4'd2:    m = 34'h1_0000_0000;
      4'd3:    m = 34'h0_AAAA_AAAB;
      4'd4:    m = 34'h0_8000_0000;
      4'd5:    m = 34'h0_6666_6667;
      4'd6:    m = 34'h0_5555_5556;
      4'd7:    m = 34'h0_4924_924A;
      4'd8:    m = 34'h0_4000_0000;
      4'd9:    m = 34'h0_38E3_8E39;
      4'd10:   m = 34'h0_3333_3334;
      default: m = '0;
    endcase
    return m;
  endfunction

  soh_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .iter  (div_iter),
    .busy  (div_busy),
    .quot  (quot)
  );

  assign res_full  = rcnt == (RP_W+1)'(RES_DEPTH);
  assign res_pop   = pop && (rcnt != '0);
  assign empty     = rcnt == '0;
  assign result    = rmem[rrp];
  assign q_pop     = (state == IDLE) && q_valid;

  assign sm_data = (j == soh_pkg::CNT_W'(soh_pkg::BINS + 1)) ? old0 : rd_data;
  assign sm_sum  = {2'b00, w1} + {1'b0, w2, 1'b0} + {2'b00, sm_data} + 34'd2;
  assign acc_sum = {1'b0, rd_data} + 33'(add);
  assign s_prev  = (s == '0) ? soh_pkg::BIN_W'(soh_pkg::BINS - 1) : s - 1'b1;
  assign s_next  = (s == soh_pkg::BIN_W'(soh_pkg::BINS - 1)) ? '0 : s + 1'b1;
  assign peak_ok = ({hh, 8'b0} > prod[39:0]) && (hh > hp) && (hh > hn) &&
                   (count < soh_pkg::CAP_W'(soh_pkg::RESULT_CAP));

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    rd_addr   = '0;
    mem_we    = 1'b0;
    wa        = '0;
    wd        = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_iter  = '0;
    res_push  = 1'b0;
    res_data  = '0;
    unique case (state)
      SQ_MUL: begin
        mul_a = 34'(wk.sq);
        mul_b = 32'(wk.sq);
      end
      T_START: begin
        div_start = 1'b1;
        div_num   = 64'(wk.d2) << 47;
        div_den   = prod[47:0];
        div_iter  = 7'd64;
      end
      H_MUL: begin
        mul_a = 34'(x);
        mul_b = 32'(r);
      end
      H_REC: begin
        mul_a = recip(k);
        mul_b = 32'(prod[59:30]);
      end
      S_MUL: begin
        mul_a = 34'(r);
        mul_b = 32'(r);
      end
      M_MUL: begin
        mul_a = 34'(wk.mag);
        mul_b = 32'(w);
      end
      A_RD: rd_addr = wk.bin;
      A_WR: begin
        mem_we = 1'b1;
        wa     = wk.bin;
        wd     = acc_sum[32] ? '1 : acc_sum[31:0];
      end
      SM_RD: begin
        if (j == '0) begin
          rd_addr = soh_pkg::BIN_W'(soh_pkg::BINS - 1);
        end else if (j <= soh_pkg::CNT_W'(soh_pkg::BINS)) begin
          rd_addr = soh_pkg::BIN_W'(j - 1'b1);
        end
      end
      SM_SH: begin
        if (j >= soh_pkg::CNT_W'(2)) begin
          mem_we = 1'b1;
          wa     = soh_pkg::BIN_W'(j - soh_pkg::CNT_W'(2));
          wd     = sm_sum[33:2];
        end
      end
      MX_RD: rd_addr = j[soh_pkg::BIN_W-1:0];
      SC_RD: begin
        case (sub)
          2'd0:    rd_addr = s_prev;
          2'd1:    rd_addr = s;
          default: rd_addr = s_next;
        endcase
      end
      SC_T1: begin
        mul_a = 34'(peak);
        mul_b = 32'(cfg.peak_ratio);
      end
      SC_I1: begin
        mul_a = dp;
        mul_b = 32'({s, 1'b0}) + 32'(2 * soh_pkg::BINS);
      end
      SC_I2: begin
        mul_a = dp;
        mul_b = 32'(2 * soh_pkg::BINS);
      end
      SC_I3: begin
        div_start = 1'b1;
        div_num   = numer + 64'(prod[48:1]);
        div_den   = prod[47:0];
        div_iter  = 7'd64;
      end
      SC_EMIT: begin
        if (pend_valid && !res_full) begin
          res_push = 1'b1;
          res_data = pend;
        end
      end
      SC_END: begin
        if (!res_full) begin
          res_push = 1'b1;
          if (pend_valid) begin
            res_data = '{peak_angle: pend.peak_angle, found: 1'b1, run_end: 1'b1};
          end else begin
            res_data = '{peak_angle: 16'd0, found: 1'b0, run_end: 1'b1};
          end
        end
      end
      CLEAR: begin
        mem_we = 1'b1;
        wa     = j[soh_pkg::BIN_W-1:0];
        wd     = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod    <= {32'b0, mul_a} * {34'b0, mul_b};
    rd_data <= hist[rd_addr];
    if (mem_we) begin
      hist[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rwp  <= '0;
      rrp  <= '0;
      rcnt <= '0;
    end else begin
      if (res_push) begin
        rmem[rwp] <= res_data;
        rwp       <= rwp + 1'b1;
      end
      if (res_pop) begin
        rrp <= rrp + 1'b1;
      end
      rcnt <= rcnt + (RP_W+1)'(res_push) - (RP_W+1)'(res_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= CLEAR;
      j          <= '0;
      init_busy  <= 1'b1;
      pend_valid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (q_valid) begin
            wk <= q_entry;
            if (!q_entry.kept) begin
              state <= FIN;
            end else if (q_entry.d2 == '0) begin
              w     <= 17'h10000;
              state <= M_MUL;
            end else if (q_entry.sq == '0) begin
              state <= FIN;
            end else begin
              state <= SQ_MUL;
            end
          end
        end
        SQ_MUL:  state <= T_START;
        T_START: state <= T_WAIT;
        T_WAIT: begin
          if (!div_busy) begin
            if (|quot[63:20]) begin
              state <= FIN;
            end else begin
              x     <= {quot[19:0], 10'b0};
              r     <= Q30_ONE;
              k     <= 4'(soh_pkg::HORNER_TERMS);
              state <= H_MUL;
            end
          end
        end
        H_MUL: state <= H_REC;
        H_REC: state <= H_SUB;
        H_SUB: begin
          r <= Q30_ONE - {1'b0, prod[62:33]};
          if (k == 4'd1) begin
            n     <= '0;
            state <= S_MUL;
          end else begin
            k     <= k - 1'b1;
            state <= H_MUL;
          end
        end
        S_MUL: state <= S_RND;
        S_RND: begin
          r <= 31'((prod[61:0] + 62'h2000_0000) >> 30);
          n <= n + 1'b1;
          if (n == 2'(soh_pkg::SQUARINGS - 1)) begin
            state <= W_CALC;
          end else begin
            state <= S_MUL;
          end
        end
        W_CALC: begin
          w     <= 17'((r + 31'd8192) >> 14);
          state <= M_MUL;
        end
        M_MUL: state <= A_RD;
        A_RD: begin
          add   <= 17'((prod[32:0] + 33'd32768) >> 16);
          state <= A_WR;
        end
        A_WR: state <= FIN;
        FIN: begin
          j    <= '0;
          pass <= '0;
          peak <= '0;
          if (!wk.fin) begin
            state <= IDLE;
          end else if (cfg.smooth_count == '0) begin
            state <= MX_RD;
          end else begin
            state <= SM_RD;
          end
        end
        SM_RD: state <= SM_SH;
        SM_SH: begin
          w1 <= w2;
          w2 <= sm_data;
          if (j == soh_pkg::CNT_W'(1)) begin
            old0 <= rd_data;
          end
          if (j == soh_pkg::CNT_W'(soh_pkg::BINS + 1)) begin
            j    <= '0;
            pass <= pass + 1'b1;
            if (3'(pass + 1'b1) == cfg.smooth_count) begin
              state <= MX_RD;
            end else begin
              state <= SM_RD;
            end
          end else begin
            j     <= j + 1'b1;
            state <= SM_RD;
          end
        end
        MX_RD: state <= MX_SH;
        MX_SH: begin
          if (rd_data > peak) begin
            peak <= rd_data;
          end
          if (j == soh_pkg::CNT_W'(soh_pkg::BINS - 1)) begin
            s     <= '0;
            sub   <= '0;
            count <= '0;
            state <= SC_RD;
          end else begin
            j     <= j + 1'b1;
            state <= MX_RD;
          end
        end
        SC_RD: state <= SC_SH;
        SC_SH: begin
          case (sub)
            2'd0:    hp <= rd_data;
            2'd1:    hh <= rd_data;
            default: hn <= rd_data;
          endcase
          if (sub == 2'd2) begin
            state <= SC_T1;
          end else begin
            sub   <= sub + 1'b1;
            state <= SC_RD;
          end
        end
        SC_T1: state <= SC_T2;
        SC_T2: begin
          if (peak_ok) begin
            dp    <= {1'b0, hh, 1'b0} - {2'b00, hp} - {2'b00, hn};
            state <= SC_I1;
          end else begin
            state <= SC_NEXT;
          end
        end
        SC_I1: state <= SC_I2;
        SC_I2: begin
          numer <= (64'(prod[41:0]) + 64'(hn) - 64'(hp)) << 16;
          state <= SC_I3;
        end
        SC_I3: state <= SC_IW;
        SC_IW: begin
          if (!div_busy) begin
            state <= SC_EMIT;
          end
        end
        SC_EMIT: begin
          if (!pend_valid || !res_full) begin
            pend       <= '{peak_angle: quot[15:0], found: 1'b1, run_end: 1'b0};
            pend_valid <= 1'b1;
            count      <= count + 1'b1;
            state      <= SC_NEXT;
          end
        end
        SC_NEXT: begin
          if (s == soh_pkg::BIN_W'(soh_pkg::BINS - 1)) begin
            state <= SC_END;
          end else begin
            s     <= s + 1'b1;
            sub   <= '0;
            state <= SC_RD;
          end
        end
        SC_END: begin
          if (!res_full) begin
            pend_valid <= 1'b0;
            j          <= '0;
            state      <= CLEAR;
          end
        end
        CLEAR: begin
          if (j == soh_pkg::CNT_W'(soh_pkg::BINS - 1)) begin
            init_busy <= 1'b0;
            state     <= IDLE;
          end else begin
            j <= j + 1'b1;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `SOH_ASSERT_IMP(a_div_idle_start, div_start, !div_busy)
  `SOH_ASSERT_IMP(a_res_room, res_push, !res_full)
  `SOH_ASSERT_IMP(a_hist_write_state, mem_we,
                  (state == A_WR) || (state == SM_SH) || (state == CLEAR))
  `SOH_ASSERT_NXT(a_pop_leaves_idle, q_pop, state != IDLE)

endmodule

`default_nettype wire

// ===== sv/sift_orientation_histogram_core.sv =====
// Top level of the keypoint orientation histogram: configuration registers,
// front end and back end. Depends on soh_pkg, soh_front and soh_back.
//
//   channel   direction  handshake          payload
//   item      in         push / full        soh_pkg::item_t
//   result    out        pop / empty        soh_pkg::res_t
//   cfg       in         cfg_write          cfg_index, cfg_data
//
// A sample outside the border or window goes from IDLE straight to FIN in the back end;
// a kept sample's time is set mostly by the shared one-bit-per-cycle divider,
// which forms 64 quotient bits for the exponent, and by ten series terms.
// A final sample adds the smoothing passes, the scan for the maximum, the peak
// scan over every bin and the clearing of the histogram memory.
// After reset, full stays high while the histogram is cleared.
// The front end keeps taking beats into a two-entry queue while the back end
// works; results wait in a four-entry queue and stall only the back end.
`default_nettype none

module sift_orientation_histogram_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  soh_pkg::item_t item,
  output logic           empty,
  input  logic           pop,
  output soh_pkg::res_t  result,
  input  logic           cfg_write,
  input  logic [1:0]     cfg_index,
  input  logic [11:0]    cfg_data
);

  soh_pkg::cfg_t  cfg;
  logic           q_valid;
  soh_pkg::work_t q_entry;
  logic           q_pop;
  logic           init_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_factor <= 12'd384;
      cfg.radius_factor <= 12'd1152;
      cfg.peak_ratio    <= 8'd205;
      cfg.smooth_count  <= 3'd2;
    end else if (cfg_write) begin
      unique case (soh_pkg::cfg_reg_e'(cfg_index))
        soh_pkg::REG_WINDOW_FACTOR: cfg.window_factor <= cfg_data;
        soh_pkg::REG_RADIUS_FACTOR: cfg.radius_factor <= cfg_data;
        soh_pkg::REG_PEAK_RATIO:    cfg.peak_ratio    <= cfg_data[7:0];
        soh_pkg::REG_SMOOTH_COUNT:  cfg.smooth_count  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  soh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cfg       (cfg),
    .init_busy (init_busy),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop)
  );

  soh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

endmodule

`default_nettype wire

// ===== tb/sift_orientation_histogram_checker.sv =====
// Scoreboard for the orientation histogram core: watches the item, result and
// register ports, predicts the orientation beats and compares them field by field.
// Depends on soh_pkg.
`default_nettype none

module sift_orientation_histogram_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  logic           full,
  input  soh_pkg::item_t item,
  input  logic           empty,
  input  logic           pop,
  input  soh_pkg::res_t  result,
  input  logic           cfg_write,
  input  logic [1:0]     cfg_index,
  input  logic [11:0]    cfg_data,
  output int             failures,
  output int             pending
);

  logic [11:0]   win_f, rad_f;
  logic [7:0]    ratio;
  logic [2:0]    passes;
  logic [31:0]   hist [soh_pkg::BINS];
  soh_pkg::res_t orient_q [$];

  function automatic logic [63:0] gauss_weight(logic [63:0] tq);
    logic [63:0] x, r;
    if (tq >= (64'd16 << 16)) return 0;
    x = tq << 10;
    r = 64'd1 << 30;
    for (int k = soh_pkg::HORNER_TERMS; k >= 1; k--)
      r = (64'd1 << 30) - ((x * r) >> 30) / 64'(k);
    for (int n = 0; n < soh_pkg::SQUARINGS; n++) r = (r * r + (64'd1 << 29)) >> 30;
    return (r + 64'd8192) >> 14;
  endfunction

  task automatic take_sample(soh_pkg::item_t it);
    int            nx, ny, ox, oy;
    logic [63:0]   rad, d2, sq, w, sum, h, p, n, dp, num, den, pk;
    logic [31:0]   old [soh_pkg::BINS];
    int            bin, cnt;
    soh_pkg::res_t r;
    ox  = $signed(it.offset_x);
    oy  = $signed(it.offset_y);
    nx  = int'(it.key_x) + ox;
    ny  = int'(it.key_y) + oy;
    rad = (64'(it.kp_scale) * 64'(rad_f) + 64'd32768) >> 16;
    if (rad > 64'(soh_pkg::MAX_RADIUS)) rad = 64'(soh_pkg::MAX_RADIUS);
    d2  = 64'(ox * ox + oy * oy);
    if (nx >= 1 && nx < int'(it.level_width) - 1 && ny >= 1 &&
        ny < int'(it.level_height) - 1 && d2 <= rad * rad) begin
      sq  = 64'(it.kp_scale) * 64'(win_f);
      bin = int'((64'(soh_pkg::BINS) * 64'(it.grad_angle) + 64'd32768) >> 16);
      if (bin >= soh_pkg::BINS) bin = 0;
      if (d2 == 0) w = 65536;
      else if (sq == 0) w = 0;
      else w = gauss_weight((d2 << 47) / (sq * sq));
      sum = 64'(hist[bin]) + ((64'(it.grad_magnitude) * w + 64'd32768) >> 16);
      hist[bin] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
    end
    if (!it.final_sample) return;
    for (int s = 0; s < int'(passes); s++) begin
      old = hist;
      for (int i = 0; i < soh_pkg::BINS; i++)
        hist[i] = 32'((64'(old[(i + soh_pkg::BINS - 1) % soh_pkg::BINS]) +
                       2 * 64'(old[i]) +
                       64'(old[(i + 1) % soh_pkg::BINS]) + 2) >> 2);
    end
    pk = 0;
    for (int i = 0; i < soh_pkg::BINS; i++) if (64'(hist[i]) > pk) pk = 64'(hist[i]);
    cnt = 0;
    for (int s = 0; s < soh_pkg::BINS; s++) begin
      h = 64'(hist[s]);
      p = 64'(hist[(s + soh_pkg::BINS - 1) % soh_pkg::BINS]);
      n = 64'(hist[(s + 1) % soh_pkg::BINS]);
      if (h * 256 > pk * 64'(ratio) && h > p && h > n && cnt < soh_pkg::RESULT_CAP) begin
        dp  = 2 * h - p - n;
        num = (2 * dp * 64'(s + soh_pkg::BINS) + n - p) * 65536;
        den = 2 * dp * 64'(soh_pkg::BINS);
        r.peak_angle = 16'((num + den / 2) / den);
        r.found      = 1'b1;
        r.run_end    = 1'b0;
        orient_q     = {orient_q, r};
        cnt++;
      end
    end
    if (cnt == 0) begin
      r.peak_angle = '0;
      r.found      = 1'b0;
      r.run_end    = 1'b1;
      orient_q     = {orient_q, r};
    end else begin
      orient_q[$].run_end = 1'b1;
    end
    for (int i = 0; i < soh_pkg::BINS; i++) hist[i] = '0;
  endtask

  always @(posedge clk) begin
    soh_pkg::res_t want;
    if (rst) begin
      win_f    = 12'd384;
      rad_f    = 12'd1152;
      ratio    = 8'd205;
      passes   = 3'd2;
      for (int i = 0; i < soh_pkg::BINS; i++) hist[i] = '0;
      orient_q.delete();
      failures <= 0;
      pending  <= 0;
    end else begin
      if (cfg_write) begin
        case (soh_pkg::cfg_reg_e'(cfg_index))
          soh_pkg::REG_WINDOW_FACTOR: win_f = cfg_data;
          soh_pkg::REG_RADIUS_FACTOR: rad_f = cfg_data;
          soh_pkg::REG_PEAK_RATIO:    ratio = cfg_data[7:0];
          soh_pkg::REG_SMOOTH_COUNT:  passes = cfg_data[2:0];
          default: ;
        endcase
      end
      if (push && !full) take_sample(item);
      if (pop && !empty) begin
        if (orient_q.size() == 0) begin
          $error("orientation beat with nothing expected: angle %0d", result.peak_angle);
          failures <= failures + 1;
        end else begin
          want = orient_q.pop_front();
          if (result.peak_angle !== want.peak_angle)
            $error("peak_angle expected %0d actual %0d", want.peak_angle, result.peak_angle);
          if (result.found !== want.found)
            $error("found expected %0d actual %0d", want.found, result.found);
          if (result.run_end !== want.run_end)
            $error("run_end expected %0d actual %0d", want.run_end, result.run_end);
          if (result !== want) failures <= failures + 1;
        end
      end
      pending <= orient_q.size();
    end
  end

endmodule

`default_nettype wire

// ===== tb/sift_orientation_histogram_core_tb.sv =====
// Testbench top for the orientation histogram core: clock, reset, sample and
// register stimulus, result back-pressure and the verdict.
// Depends on soh_pkg, sift_orientation_histogram_core and the checker.
`default_nettype none

module sift_orientation_histogram_core_tb;

  localparam int LIMIT = 10_000_000;

  logic           clk, rst, push, full, empty, pop, cfg_write;
  soh_pkg::item_t item;
  soh_pkg::res_t  result;
  logic [1:0]     cfg_index;
  logic [11:0]    cfg_data;
  int             failures, pending, cycles;
  bit             calm;

  sift_orientation_histogram_core dut (
    .clk, .rst, .push, .full, .item, .empty, .pop, .result,
    .cfg_write, .cfg_index, .cfg_data
  );

  sift_orientation_histogram_checker chk (
    .clk, .rst, .push, .full, .item, .empty, .pop, .result,
    .cfg_write, .cfg_index, .cfg_data, .failures, .pending
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = int'($urandom_range(0, 19));
    if (calm || roll < 12) return 0;
    if (roll < 19) return int'($urandom_range(1, 4));
    return int'($urandom_range(20, 80));
  endfunction

  initial begin
    int g;
    pop = 0;
    g = 0;
    forever begin
      @(negedge clk);
      pop = (g == 0);
      if (g > 0) g--;
      @(posedge clk);
      if (pop && !empty) g = pick_gap();
    end
  end

  task automatic send_beat(soh_pkg::item_t it);
    int g;
    g = pick_gap();
    repeat (g) begin
      @(negedge clk);
      push = 0;
    end
    @(negedge clk);
    push = 1;
    item = it;
    do @(posedge clk); while (full);
  endtask

  task automatic write_reg(soh_pkg::cfg_reg_e idx, logic [11:0] val);
    @(negedge clk);
    cfg_write = 1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_write = 0;
  endtask

  task automatic settle();
    @(negedge clk);
    push = 0;
    while (pending != 0 || chk.orient_q.size() != 0) @(posedge clk);
    repeat (4000) @(posedge clk);
  endtask

  task automatic program_regs(logic [11:0] w, logic [11:0] r, logic [7:0] pr,
                              logic [2:0] sc);
    write_reg(soh_pkg::REG_WINDOW_FACTOR, w);
    write_reg(soh_pkg::REG_RADIUS_FACTOR, r);
    write_reg(soh_pkg::REG_PEAK_RATIO, {4'd0, pr});
    write_reg(soh_pkg::REG_SMOOTH_COUNT, {9'd0, sc});
  endtask

  // A keypoint: n samples sharing position and scale, the last one final.
  // Tidy keypoints keep samples inside the border and mostly inside the window.
  task automatic send_keypoint(int n, bit tidy);
    soh_pkg::item_t it;
    int             span, center;
    it.key_x          = 12'($urandom_range(0, 4095));
    it.key_y          = 12'($urandom_range(0, 4095));
    it.level_width    = 13'($urandom_range(0, 4096));
    it.level_height   = 13'($urandom_range(0, 4096));
    it.kp_scale       = 12'($urandom_range(0, 4095));
    center            = int'($urandom_range(0, 65535));
    calm              = ($urandom_range(0, 4) == 0);
    if (tidy) begin
      it.key_x        = 12'($urandom_range(130, 3960));
      it.key_y        = 12'($urandom_range(130, 3960));
      it.level_width  = 13'd4096;
      it.level_height = 13'd4096;
      it.kp_scale     = 12'($urandom_range(128, 4095));
    end
    span = ((int'(it.kp_scale) * 1152) >> 16) + 1;
    for (int i = 0; i < n; i++) begin
      if (tidy && $urandom_range(0, 5) != 0) begin
        it.offset_x   = 8'(int'($urandom_range(0, 2 * span)) - span);
        it.offset_y   = 8'(int'($urandom_range(0, 2 * span)) - span);
        it.grad_angle = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 65535))
                        : 16'(center + int'($urandom_range(0, 4000)));
      end else begin
        it.offset_x   = 8'($urandom_range(0, 255));
        it.offset_y   = 8'($urandom_range(0, 255));
        it.grad_angle = 16'($urandom_range(0, 65535));
      end
      it.grad_magnitude = 16'($urandom_range(0, 65535));
      it.final_sample   = (i == n - 1);
      send_beat(it);
    end
  endtask

  task automatic random_phase(int items);
    int done, n;
    done = 0;
    while (done < items) begin
      n = int'($urandom_range(1, 8));
      send_keypoint(n, $urandom_range(0, 4) != 0);
      done += n;
    end
    settle();
  endtask

  initial begin
    soh_pkg::item_t it;
    rst = 1;
    push = 0;
    cfg_write = 0;
    cfg_index = '0;
    cfg_data = '0;
    item = '0;
    calm = 0;
    cycles = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Extremes of the fields under the reset register values.
    it = '{key_x: 12'd10, key_y: 12'd10, level_width: 13'd4096, level_height: 13'd4096,
           kp_scale: 12'd4095, offset_x: 8'sd0, offset_y: 8'sd0, grad_angle: 16'd0,
           grad_magnitude: 16'hFFFF, final_sample: 1'b0};
    send_beat(it);
    it.grad_angle = 16'hFFFF; it.grad_magnitude = 16'd1; it.offset_x = 8'sd3;
    send_beat(it);
    it.key_x = 12'd200; it.key_y = 12'd200;
    it.offset_x = 8'sh80; it.offset_y = 8'sh80; it.grad_angle = 16'h8000;
    send_beat(it);
    it.offset_x = 8'sd127; it.offset_y = 8'sd127;
    send_beat(it);
    it.key_x = 12'd0; it.key_y = 12'd4095; it.offset_x = 8'sd1; it.offset_y = -8'sd1;
    send_beat(it);
    it.key_x = 12'd2000; it.key_y = 12'd2000; it.offset_x = 8'sd5; it.offset_y = -8'sd4;
    it.grad_angle = 16'h4000; it.grad_magnitude = 16'hFFFF;
    send_beat(it);
    it.level_width = 13'd0; it.level_height = 13'd0; it.final_sample = 1'b1;
    send_beat(it);
    // Two keypoints whose only sample is rejected give no peak.
    it.level_width = 13'd2; it.level_height = 13'd1;
    send_beat(it);
    it.level_width = 13'd4096; it.level_height = 13'd4096; it.kp_scale = 12'd0;
    it.offset_x = 8'sd1; it.offset_y = 8'sd0;
    send_beat(it);
    random_phase(70);

    // Zero sigma and wide window; no smoothing and no threshold give 18 peaks.
    program_regs(12'd0, 12'd4095, 8'd0, 3'd0);
    it.key_x = 12'd100; it.key_y = 12'd100; it.kp_scale = 12'd4095;
    it.offset_x = 8'sd0; it.offset_y = 8'sd0;
    for (int b = 0; b < 18; b++) begin
      it.grad_angle     = 16'((2 * b * 65536) / soh_pkg::BINS);
      it.grad_magnitude = 16'(1000 + 37 * b);
      it.final_sample   = (b == 17);
      send_beat(it);
    end
    it.offset_x = 8'sd2; it.final_sample = 1'b1;
    send_beat(it);
    random_phase(70);

    program_regs(12'd4095, 12'd0, 8'd255, 3'd7);
    random_phase(60);
    program_regs(12'd256, 12'd4095, 8'd128, 3'd1);
    random_phase(70);
    program_regs(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
    random_phase(70);

    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
